/* sv/assert_macros.svh */
// Assertion macros shared by the RTL of the double-click detector.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define DDDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication: when cond holds, then holds in the same cycle.
`define DDDC_ASSERT_IMP(lbl, cond, then_expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (then_expr)) \
    else $error(msg);

`endif

/* sv/dddc_pkg.sv */
// Shared types and constants for the debounced double-click detector.
// No dependencies.
package dddc_pkg;

  localparam int DEBOUNCE_W = 10;
  localparam int GAP_W      = 16;
  localparam int COUNT_W    = 4;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 10'd20;
  localparam logic [GAP_W-1:0]      GAP_RESET      = 16'd300;

  localparam logic [COUNT_W-1:0] CLICKS_FOR_ACTION = 4'd2;
  localparam logic [COUNT_W-1:0] COUNT_MAX         = 4'd15;

  // Register indexes of the configuration port
  localparam logic CFG_DEBOUNCE = 1'b0;
  localparam logic CFG_GAP      = 1'b1;

  // Sampled key codes
  localparam logic [1:0] KEY_NONE = 2'd0;
  localparam logic [1:0] KEY_ONE  = 2'd1;
  localparam logic [1:0] KEY_TWO  = 2'd2;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_STANDBY = 2'd1,
    ACT_REPORT  = 2'd2
  } action_t;

  // Per-poll status flags handed to the core
  typedef struct packed {
    logic [1:0] key_code;
    logic       charging;
    logic       connected;
  } poll_flags_t;

  // One result, packed in tdata order from the top bit down
  typedef struct packed {
    logic               keep_polling;
    logic               key_is_down;
    logic [COUNT_W-1:0] clicks_so_far;
    action_t            action;
  } result_t;

endpackage

/* sv/dddc_core.sv */
// Debounce and click-burst state with its combinational next-state logic.
// Depends on dddc_pkg.
module dddc_core import dddc_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  poll_flags_t           flags,
  input  logic [TIME_BITS-1:0]  now,
  input  logic [DEBOUNCE_W-1:0] debounce_ms,
  input  logic [GAP_W-1:0]      click_gap_ms,
  output result_t               result
);

  logic                 pressed_r, pressed_nxt;
  logic [1:0]           pending_key_r, pending_key_nxt;
  logic [TIME_BITS-1:0] press_stamp_r, press_stamp_nxt;
  logic [TIME_BITS-1:0] release_stamp_r, release_stamp_nxt;
  logic [COUNT_W-1:0]   click_count_r, click_count_nxt;
  logic [TIME_BITS-1:0] last_click_r, last_click_nxt;
  logic [1:0]           burst_key_r, burst_key_nxt;

  logic                 down;
  logic [TIME_BITS-1:0] stamp;
  logic [TIME_BITS-1:0] deb_span, gap_span;
  logic [TIME_BITS-1:0] since_press, since_release, since_click;
  logic                 press_ok, release_ok, gap_done;
  logic                 burst_close, click_done;
  logic [COUNT_W-1:0]   count_mid;
  action_t              action;

  assign down  = (flags.key_code != KEY_NONE);
  assign stamp = now | TIME_BITS'(1);

  // Wrapping elapsed times against the stored stamps
  assign deb_span      = TIME_BITS'(debounce_ms);
  assign gap_span      = TIME_BITS'(click_gap_ms);
  assign since_press   = now - press_stamp_r;
  assign since_release = now - release_stamp_r;
  assign since_click   = now - last_click_r;
  assign press_ok      = since_release > deb_span;
  assign release_ok    = since_press > deb_span;
  assign gap_done      = since_click > gap_span;

  assign burst_close = (click_count_r != '0) && (last_click_r != '0) && gap_done;
  assign click_done  = (pending_key_r != KEY_NONE) && !down && release_ok;

  // Burst decision on close
  always_comb begin
    action = ACT_NONE;
    if (burst_close && !flags.charging && click_count_r == CLICKS_FOR_ACTION) begin
      if (burst_key_r == KEY_ONE) begin
        action = ACT_STANDBY;
      end else if (burst_key_r == KEY_TWO && flags.connected) begin
        action = ACT_REPORT;
      end
    end
  end

  // Next state: debounce edges, then close, then a new click
  always_comb begin
    pressed_nxt       = pressed_r;
    press_stamp_nxt   = press_stamp_r;
    release_stamp_nxt = release_stamp_r;
    pending_key_nxt   = pending_key_r;
    burst_key_nxt     = burst_key_r;
    last_click_nxt    = last_click_r;

    if (down) begin
      if (!pressed_r && press_ok) begin
        pressed_nxt     = 1'b1;
        press_stamp_nxt = stamp;
        pending_key_nxt = flags.key_code;
      end
    end else if (pressed_r && release_ok) begin
      pressed_nxt       = 1'b0;
      release_stamp_nxt = stamp;
    end

    count_mid = click_count_r;
    if (burst_close) begin
      count_mid      = '0;
      last_click_nxt = '0;
      burst_key_nxt  = KEY_NONE;
    end

    click_count_nxt = count_mid;
    if (click_done) begin
      if (count_mid < COUNT_MAX) begin
        click_count_nxt = count_mid + COUNT_W'(1);
      end
      last_click_nxt  = stamp;
      burst_key_nxt   = pending_key_r;
      pending_key_nxt = KEY_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r       <= 1'b0;
      pending_key_r   <= KEY_NONE;
      press_stamp_r   <= '0;
      release_stamp_r <= '0;
      click_count_r   <= '0;
      last_click_r    <= '0;
      burst_key_r     <= KEY_NONE;
    end else if (step_en) begin
      pressed_r       <= pressed_nxt;
      pending_key_r   <= pending_key_nxt;
      press_stamp_r   <= press_stamp_nxt;
      release_stamp_r <= release_stamp_nxt;
      click_count_r   <= click_count_nxt;
      last_click_r    <= last_click_nxt;
      burst_key_r     <= burst_key_nxt;
    end
  end

  assign result.action        = action;
  assign result.clicks_so_far = click_count_nxt;
  assign result.key_is_down   = pressed_nxt;
  assign result.keep_polling  = down || (click_count_nxt != '0);

endmodule

/* sv/debounced_double_click_detector_top.sv */
// Top level of the debounced double-click detector: stream ports, config
// registers, input and output registers. Depends on dddc_pkg, dddc_core
// and assert_macros.svh.
//
// Usage: each poll transaction on the in_ channel carries the sampled key,
// the millisecond time and the charging/connected flags. Every poll yields
// exactly one result transaction on the out_ channel with the burst action,
// the click count, the debounced key state and a keep-polling hint.
// A poll accepted into the input register is evaluated by dddc_core and its
// result is registered for out_tdata. Throughput: one poll per cycle while
// out_tready is high; the whole step is a few wrapping subtracts and
// compares in dddc_core between the input and output register.
// Stall: while out_tready is low the result holds; the input register still
// takes one more poll, then in_tready drops until the result is taken.
// Reset: rst_n (synchronous) clears all state, empties both registers and
// loads debounce_ms = 20 and click_gap_ms = 300. Configuration writes are
// taken any cycle but are meant for idle periods.
module debounced_double_click_detector_top import dddc_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // poll input; tdata: key_code[1:0], now_ms[33:2], charging[34],
  // connected[35], zero pad[39:36]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,
  // result output; tdata: action[1:0], clicks_so_far[5:2], key_is_down[6],
  // keep_polling[7]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,
  // configuration write port
  input  logic        cfg_wen,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic                  in_valid_r;
  poll_flags_t           flags_r;
  logic [TIME_BITS-1:0]  now_r, now_nxt;
  logic                  out_valid_r, out_valid_nxt;
  result_t               out_data_r;
  result_t               core_result;
  logic [DEBOUNCE_W-1:0] debounce_r;
  logic [GAP_W-1:0]      gap_r;
  logic                  in_take, advance;

  // Fit the 32-bit time into the stamp width
  generate
    if (TIME_BITS > 32) begin : g_time_ext
      assign now_nxt = {{(TIME_BITS-32){1'b0}}, in_tdata[33:2]};
    end else if (TIME_BITS == 32) begin : g_time_eq
      assign now_nxt = in_tdata[33:2];
    end else begin : g_time_cut
      assign now_nxt = in_tdata[TIME_BITS+1:2];
    end
  endgenerate

  // Handshake: core step fires on a held poll when the output can take it
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      flags_r.key_code  <= in_tdata[1:0];
      flags_r.charging  <= in_tdata[34];
      flags_r.connected <= in_tdata[35];
      now_r             <= now_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= core_result;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RESET;
      gap_r      <= GAP_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_DEBOUNCE: debounce_r <= cfg_wdata[DEBOUNCE_W-1:0];
        CFG_GAP:      gap_r      <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  dddc_core #(
    .TIME_BITS(TIME_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (advance),
    .flags        (flags_r),
    .now          (now_r),
    .debounce_ms  (debounce_r),
    .click_gap_ms (gap_r),
    .result       (core_result)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`include "assert_macros.svh"

  // A held result with a full input register must block the input side
  `DDDC_ASSERT_IMP(a_stall_blocks_input, in_valid_r && out_valid_r && !out_tready, !in_tready, "input accepted while both registers are full and output stalled")
  // A burst action leaves at most the one click that opened a new burst
  `DDDC_ASSERT_IMP(a_action_count, out_valid_r && out_data_r.action != ACT_NONE, out_data_r.clicks_so_far <= 4'd1, "action reported with an open multi-click burst")
  // A nonzero count always keeps polling
  `DDDC_ASSERT_IMP(a_count_polls, out_valid_r && out_data_r.clicks_so_far != '0, out_data_r.keep_polling, "open burst without keep_polling")

endmodule

/* tb/debounced_double_click_detector_top_tb.sv */
// Self-checking testbench for the debounced double-click detector top level.
// Drives polls; checks each result against a cycle-free click model or a pinned
// table row. Depends on dddc_pkg and debounced_double_click_detector_top.
`timescale 1ns / 100ps

module debounced_double_click_detector_top_tb import dddc_pkg::*;;

  localparam int          DIR_ROWS    = 26;
  localparam int          PHASE_POLLS = 440;
  localparam int unsigned CYCLE_LIMIT = 200000;
  // key code three: a pressed key of unknown identity
  localparam logic [1:0]  KEY_ANY     = 2'd3;

  // poll word in tdata order, top bit first
  typedef struct packed {
    logic [3:0]  pad;
    logic        connected;
    logic        charging;
    logic [31:0] now_ms;
    logic [1:0]  key_code;
  } poll_t;

  typedef struct packed {
    poll_t   poll;
    logic    pinned;
    result_t res;
  } dir_row_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        cfg_wen    = 1'b0;
  logic        cfg_index  = CFG_DEBOUNCE;
  logic [15:0] cfg_wdata  = '0;

  // expectation typed in the directed table, travels with the poll
  logic    pin_vld = 1'b0;
  result_t pin_res = '0;

  int          snd_idle_pct  = 0;
  int          rcv_stall_pct = 0;
  logic        rcv_hold      = 1'b0;
  int          phase_no      = -1;
  int          err_cnt       = 0;
  int unsigned cyc_cnt       = 0;

  // configuration as the block should hold it
  logic [DEBOUNCE_W-1:0] deb_ms = DEBOUNCE_RESET;
  logic [GAP_W-1:0]      gap_ms = GAP_RESET;

  // click state mirrored from the block
  logic               btn_down;
  logic [1:0]         armed_key;
  logic [31:0]        press_ts;
  logic [31:0]        release_ts;
  logic [COUNT_W-1:0] click_cnt;
  logic [31:0]        last_click_ts;
  logic [1:0]         burst_key;

  result_t     due_q [$];
  poll_t       poll_q [$];
  logic [31:0] t_now = '0;
  dir_row_t    dir_tbl [DIR_ROWS];
  result_t     got_res;
  result_t     want_res;

  debounced_double_click_detector_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // modulo-2^32 elapsed time, strictly past the span
  function automatic logic span_passed(logic [31:0] now, logic [31:0] stamp,
                                       logic [31:0] span);
    logic [31:0] dt;
    dt = now - stamp;
    return dt > span;
  endfunction

  // one poll through the debounce and burst logic
  function automatic result_t click_step(poll_t p);
    logic [31:0] stamp;
    logic        down;
    result_t     r;
    stamp = p.now_ms | 32'd1;
    down = (p.key_code != KEY_NONE);
    r.action = ACT_NONE;

    // debounce the edges
    if (down) begin
      if (!btn_down && span_passed(p.now_ms, release_ts, 32'(deb_ms))) begin
        btn_down = 1'b1;
        press_ts = stamp;
        armed_key = p.key_code;
      end
    end else if (btn_down && span_passed(p.now_ms, press_ts, 32'(deb_ms))) begin
      release_ts = stamp;
      btn_down = 1'b0;
    end

    // close a quiet burst
    if (click_cnt != 0 && last_click_ts != 0 &&
        span_passed(p.now_ms, last_click_ts, 32'(gap_ms))) begin
      if (!p.charging && click_cnt == CLICKS_FOR_ACTION) begin
        if (burst_key == KEY_ONE)
          r.action = ACT_STANDBY;
        else if (burst_key == KEY_TWO && p.connected)
          r.action = ACT_REPORT;
      end
      click_cnt = '0;
      last_click_ts = '0;
      burst_key = KEY_NONE;
    end

    // count a completed click
    if (armed_key != KEY_NONE && !down && span_passed(p.now_ms, press_ts, 32'(deb_ms))) begin
      if (click_cnt < COUNT_MAX)
        click_cnt = click_cnt + 1'b1;
      last_click_ts = stamp;
      burst_key = armed_key;
      armed_key = KEY_NONE;
    end

    r.clicks_so_far = click_cnt;
    r.key_is_down = btn_down;
    r.keep_polling = down || (click_cnt != 0);
    return r;
  endfunction

  // result check first, then the prediction for a poll taken at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got_res = result_t'(out_tdata);
        if (due_q.size() == 0) begin
          err_cnt++;
          $error("result transaction with no poll outstanding: %h", out_tdata);
        end else begin
          want_res = due_q.pop_front();
          if (got_res.action !== want_res.action) begin
            err_cnt++;
            $error("action: expected %0d, actual %0d", want_res.action, got_res.action);
          end
          if (got_res.clicks_so_far !== want_res.clicks_so_far) begin
            err_cnt++;
            $error("clicks_so_far: expected %0d, actual %0d",
                   want_res.clicks_so_far, got_res.clicks_so_far);
          end
          if (got_res.key_is_down !== want_res.key_is_down) begin
            err_cnt++;
            $error("key_is_down: expected %0d, actual %0d",
                   want_res.key_is_down, got_res.key_is_down);
          end
          if (got_res.keep_polling !== want_res.keep_polling) begin
            err_cnt++;
            $error("keep_polling: expected %0d, actual %0d",
                   want_res.keep_polling, got_res.keep_polling);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        want_res = click_step(poll_t'(in_tdata));
        if (pin_vld)
          want_res = pin_res;
        due_q.push_back(want_res);
      end
    end
  end

  // receiver: random stalls plus the long hold-off
  always @(posedge clk) begin
    out_tready <= !rcv_hold && ($urandom_range(99) >= rcv_stall_pct);
  end

  // long hold-off early in the first random phase so the block backs up
  initial begin
    wait (phase_no == 0);
    repeat (100) @(posedge clk);
    rcv_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rcv_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic dir_row_t tbl_entry(logic [1:0] k, logic [31:0] t, logic chg,
                                         logic con, logic pin, action_t act);
    dir_row_t e;
    e.poll = '{pad: 4'd0, connected: con, charging: chg, now_ms: t, key_code: k};
    e.pinned = pin;
    e.res = '{keep_polling: 1'b0, key_is_down: 1'b0, clicks_so_far: '0, action: act};
    return e;
  endfunction

  task automatic send_poll(poll_t p, logic pin, result_t res);
    in_tvalid <= 1'b1;
    in_tdata <= p;
    pin_vld <= pin;
    pin_res <= res;
    do @(posedge clk); while (!in_tready);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
  endtask

  task automatic set_config(logic [15:0] deb_val, logic [15:0] gap_val);
    cfg_wen <= 1'b1;
    cfg_index <= CFG_DEBOUNCE;
    cfg_wdata <= deb_val;
    @(posedge clk);
    cfg_index <= CFG_GAP;
    cfg_wdata <= gap_val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    deb_ms = deb_val[DEBOUNCE_W-1:0];
    gap_ms = gap_val;
  endtask

  task automatic add_poll(logic [1:0] k, logic [31:0] dt, logic chg, logic con);
    t_now += dt;
    poll_q.push_back('{pad: 4'd0, connected: con, charging: chg, now_ms: t_now,
                       key_code: k});
  endtask

  // one burst of clicks with bounces, then quiet for at least the click gap
  task automatic queue_burst();
    logic [1:0] k;
    int         n;
    int         r;
    logic       chg;
    logic       con;
    r = $urandom_range(9);
    k = (r < 5) ? KEY_ONE : (r < 9) ? KEY_TWO : KEY_ANY;
    r = $urandom_range(19);
    n = (r < 10) ? 2 : (r < 14) ? 1 : (r < 17) ? 3 : (r < 19) ? 4 : $urandom_range(14, 18);
    chg = ($urandom_range(3) == 0);
    con = ($urandom_range(3) != 0);
    for (int i = 0; i < n; i++) begin
      // early press right after the release, most often rejected
      if ($urandom_range(7) == 0)
        add_poll(k, $urandom_range(0, deb_ms), chg, con);
      add_poll(k, 32'(deb_ms) + $urandom_range(1, 4), chg, con);
      repeat ($urandom_range(0, 2)) add_poll(k, $urandom_range(0, 3), chg, con);
      // release bounce inside the hold time
      if ($urandom_range(5) == 0) begin
        add_poll(KEY_NONE, $urandom_range(0, deb_ms / 2), chg, con);
        add_poll(k, $urandom_range(0, 2), chg, con);
      end
      add_poll(KEY_NONE, 32'(deb_ms) + $urandom_range(1, 4), chg, con);
    end
    repeat ($urandom_range(0, 2)) add_poll(KEY_NONE, $urandom_range(0, gap_ms / 2), chg, con);
    add_poll(KEY_NONE, 32'(gap_ms) + $urandom_range(0, 6),
             chg ^ ($urandom_range(7) == 0), con ^ ($urandom_range(7) == 0));
  endtask

  // random polls anywhere in time, some close to the wrap point
  task automatic queue_noise();
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(3) == 0)
        t_now = 32'hFFFF_FFFF - $urandom_range(0, 2 * deb_ms + 8);
      add_poll(2'($urandom_range(0, 3)), $urandom(), 1'($urandom_range(1)),
               1'($urandom_range(1)));
    end
  endtask

  task automatic run_phase(int ph, int snd_pct, int rcv_pct, logic [15:0] deb_val,
                           logic [15:0] gap_val);
    set_config(deb_val, gap_val);
    snd_idle_pct = snd_pct;
    rcv_stall_pct = rcv_pct;
    phase_no = ph;
    while (poll_q.size() < PHASE_POLLS) begin
      if ($urandom_range(9) == 0)
        queue_noise();
      else
        queue_burst();
    end
    while (poll_q.size() != 0)
      send_poll(poll_q.pop_front(), 1'b0, '0);
    in_tvalid <= 1'b0;
    while (due_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    // directed polls at reset settings: debounce 20, gap 300
    dir_tbl[0]  = tbl_entry(KEY_NONE, 32'd0,    1'b0, 1'b0, 1'b1, ACT_NONE);
    dir_tbl[1]  = tbl_entry(KEY_ONE,  32'd100,  1'b0, 1'b0, 1'b0, ACT_NONE);
    dir_tbl[2]  = tbl_entry(KEY_ONE,  32'd110,  1'b0, 1'b0, 1'b0, ACT_NONE);
    dir_tbl[3]  = tbl_entry(KEY_NONE, 32'd115,  1'b0, 1'b0, 1'b0, ACT_NONE);
    dir_tbl[4]  = tbl_entry(KEY_NONE, 32'd130,  1'b0, 1'b0, 1'b0, ACT_NONE);
    dir_tbl[5]  = tbl_entry(KEY_ONE,  32'd160,  1'b0, 1'b0, 1'b0, ACT_NONE);
    dir_tbl[6]  = tbl_entry(KEY_NONE, 32'd200,  1'b0, 1'b0, 1'b0, ACT_NONE);
    dir_tbl[7]  = tbl_entry(KEY_NONE, 32'd600,  1'b0, 1'b0, 1'b1, ACT_STANDBY);
    dir_tbl[8]  = tbl_entry(KEY_TWO,  32'd1000, 1'b0, 1'b1, 1'b0, ACT_NONE);
    dir_tbl[9]  = tbl_entry(KEY_NONE, 32'd1030, 1'b0, 1'b1, 1'b0, ACT_NONE);
    dir_tbl[10] = tbl_entry(KEY_TWO,  32'd1060, 1'b0, 1'b1, 1'b0, ACT_NONE);
    dir_tbl[11] = tbl_entry(KEY_NONE, 32'd1090, 1'b0, 1'b1, 1'b0, ACT_NONE);
    dir_tbl[12] = tbl_entry(KEY_NONE, 32'd1500, 1'b0, 1'b1, 1'b1, ACT_REPORT);
    // key two burst while disconnected
    dir_tbl[13] = tbl_entry(KEY_TWO,  32'd2000, 1'b0, 1'b0, 1'b0, ACT_NONE);
    dir_tbl[14] = tbl_entry(KEY_NONE, 32'd2030, 1'b0, 1'b0, 1'b0, ACT_NONE);
    dir_tbl[15] = tbl_entry(KEY_TWO,  32'd2060, 1'b0, 1'b0, 1'b0, ACT_NONE);
    dir_tbl[16] = tbl_entry(KEY_NONE, 32'd2090, 1'b0, 1'b0, 1'b0, ACT_NONE);
    dir_tbl[17] = tbl_entry(KEY_NONE, 32'd2500, 1'b0, 1'b0, 1'b1, ACT_NONE);
    // unknown key code, double click while charging
    dir_tbl[18] = tbl_entry(KEY_ANY,  32'd3000, 1'b1, 1'b1, 1'b0, ACT_NONE);
    dir_tbl[19] = tbl_entry(KEY_NONE, 32'd3030, 1'b1, 1'b1, 1'b0, ACT_NONE);
    dir_tbl[20] = tbl_entry(KEY_ANY,  32'd3060, 1'b1, 1'b1, 1'b0, ACT_NONE);
    dir_tbl[21] = tbl_entry(KEY_NONE, 32'd3090, 1'b1, 1'b1, 1'b0, ACT_NONE);
    // burst closes and a new click lands in the same poll
    dir_tbl[22] = tbl_entry(KEY_ONE,  32'd3300, 1'b0, 1'b1, 1'b0, ACT_NONE);
    dir_tbl[23] = tbl_entry(KEY_NONE, 32'd3400, 1'b0, 1'b1, 1'b0, ACT_NONE);
    // press at all-ones time, release after the wrap
    dir_tbl[24] = tbl_entry(KEY_ONE,  32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, ACT_NONE);
    dir_tbl[25] = tbl_entry(KEY_NONE, 32'h0000_0020, 1'b0, 1'b1, 1'b0, ACT_NONE);

    btn_down = 1'b0;
    armed_key = KEY_NONE;
    press_ts = '0;
    release_ts = '0;
    click_cnt = '0;
    last_click_ts = '0;
    burst_key = KEY_NONE;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      send_poll(dir_tbl[i].poll, dir_tbl[i].pinned, dir_tbl[i].res);
    in_tvalid <= 1'b0;
    pin_vld <= 1'b0;
    while (due_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    t_now = 32'd10000;

    // random phases: idling pattern and register settings change together
    run_phase(0, 0,  0,  16'd5,    16'd200);
    run_phase(1, 88, 0,  16'd1023, 16'd65535);
    run_phase(2, 0,  88, 16'd0,    16'd0);
    run_phase(3, 20, 20, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));

    if (err_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/dddc_pkg.sv
sv/dddc_core.sv
sv/debounced_double_click_detector_top.sv
tb/debounced_double_click_detector_top_tb.sv
